// ===== design/wcfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcfe_pkg
// Shared types and constants for the client frame encoder.
// ----------------------------------------------------------------------------
package wcfe_pkg;

	localparam int LEN_W = 63;
	localparam int KEY_W = 32;

	// input item kinds
	localparam logic OP_BEGIN   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	localparam logic [7:0]       FIN_BIT   = 8'h80;
	localparam logic [7:0]       MASK_BIT  = 8'h80;
	localparam logic [6:0]       LEN7_MAX  = 7'd125;
	localparam logic [6:0]       ESC_LEN16 = 7'd126;
	localparam logic [6:0]       ESC_LEN64 = 7'd127;
	localparam logic [LEN_W-1:0] LEN16_MAX = LEN_W'(65535);

	// last header byte index for each length form
	localparam logic [3:0] HDR_LAST_SHORT = 4'd5;
	localparam logic [3:0] HDR_LAST_MED   = 4'd7;
	localparam logic [3:0] HDR_LAST_LONG  = 4'd13;
	// first key byte index for each length form
	localparam logic [3:0] KEY_POS_SHORT  = 4'd2;
	localparam logic [3:0] KEY_POS_MED    = 4'd4;
	localparam logic [3:0] KEY_POS_LONG   = 4'd10;
	// big-endian 64-bit length: header byte 2 holds length byte 7
	localparam logic [3:0] LEN64_TOP_POS  = 4'd9;
	localparam logic [3:0] LEN16_TOP_POS  = 4'd3;

	typedef enum logic [1:0] {
		LEN_SHORT,
		LEN_MED,
		LEN_LONG
	} len_form_t;

	typedef enum logic {
		ST_IDLE,
		ST_HEADER
	} ctrl_state_t;

	typedef struct packed {
		logic begin_load;
		logic pay_load;
		logic hdr_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic hdr_last;
	} dp_status_t;

endpackage

// ===== design/websocket_client_frame_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_client_frame_encoder
// Masked client frame encoder producing one encoded byte per output beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): a begin beat (opcode 0) carries frame
// type, payload length and masking key; a payload beat (opcode 1) carries one
// byte. Output channel (out_valid/out_ready) carries one frame byte per beat
// with last_of_item, frame_done and error flags.
// A begin beat yields a 6, 8 or 14 byte header, one byte per cycle from the
// header sequencer while the output is not stalled; the next input beat is
// taken after the last header byte is loaded.
// A payload beat is masked and loaded into the output register in the cycle
// it is taken; one beat per cycle is sustained while the receiver keeps
// out_ready high. A payload beat with no open frame returns a single error
// beat and leaves the frame state alone.
// When the receiver stalls, the output register holds its beat and in_ready
// drops until that beat is taken. Reset clears the open frame, stored key,
// key index and output valid.
// ----------------------------------------------------------------------------
module websocket_client_frame_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic [3:0]                 frame_type,
	input  logic [wcfe_pkg::LEN_W-1:0] payload_length,
	input  logic [wcfe_pkg::KEY_W-1:0] masking_key,
	input  logic [7:0]                 payload_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       last_of_item,
	output logic                       frame_done,
	output logic                       error
);

	wcfe_pkg::ctrl_cmd_t  cmd;
	wcfe_pkg::dp_status_t status;

	wcfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	wcfe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.frame_type     (frame_type),
		.payload_length (payload_length),
		.masking_key    (masking_key),
		.payload_byte   (payload_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.last_of_item   (last_of_item),
		.frame_done     (frame_done),
		.error          (error)
	);

endmodule

// ===== design/wcfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcfe_ctrl
// Sequencer: takes items while idle, walks the header bytes after a begin.
// ----------------------------------------------------------------------------
module wcfe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                opcode,
	output logic                in_ready,
	input  wcfe_pkg::dp_status_t status,
	output wcfe_pkg::ctrl_cmd_t  cmd
);

	wcfe_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd.begin_load = 1'b0;
		cmd.pay_load   = 1'b0;
		cmd.hdr_emit   = 1'b0;
		case (state_q)
			wcfe_pkg::ST_IDLE: begin
				in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					if (opcode == wcfe_pkg::OP_BEGIN) begin
						cmd.begin_load = 1'b1;
						state_d        = wcfe_pkg::ST_HEADER;
					end else begin
						cmd.pay_load = 1'b1;
					end
				end
			end
			wcfe_pkg::ST_HEADER: begin
				cmd.hdr_emit = status.out_free;
				if (status.out_free && status.hdr_last) begin
					state_d = wcfe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wcfe_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/wcfe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcfe_dp
// Frame state, header byte selection, payload masking and output register.
// ----------------------------------------------------------------------------
module wcfe_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wcfe_pkg::ctrl_cmd_t        cmd,
	output wcfe_pkg::dp_status_t       status,
	input  logic [3:0]                 frame_type,
	input  logic [wcfe_pkg::LEN_W-1:0] payload_length,
	input  logic [wcfe_pkg::KEY_W-1:0] masking_key,
	input  logic [7:0]                 payload_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       last_of_item,
	output logic                       frame_done,
	output logic                       error
);

	logic [wcfe_pkg::LEN_W-1:0] bytes_left_q;
	logic [wcfe_pkg::LEN_W-1:0] len_q;
	logic [wcfe_pkg::KEY_W-1:0] key_q;
	logic [3:0]                 type_q;
	logic [1:0]                 key_index_q;
	logic                       frame_open_q;
	logic                       len_zero_q;
	wcfe_pkg::len_form_t        form_q;
	logic [3:0]                 hdr_idx_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       done_q;
	logic       err_q;

	wcfe_pkg::len_form_t form_in;
	logic [7:0]          hdr_byte;
	logic [3:0]          hdr_last_idx;
	logic [3:0]          key_pos;
	logic [3:0]          key_off;
	logic [3:0]          len_sel;
	logic [63:0]         len_shifted;
	logic                in_key;
	logic                last_payload;

	function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] j);
		logic [31:0] sh;
		sh = key << {j, 3'b000};
		return sh[31:24];
	endfunction

	always_comb begin
		if (payload_length <= wcfe_pkg::LEN_W'(wcfe_pkg::LEN7_MAX)) begin
			form_in = wcfe_pkg::LEN_SHORT;
		end else if (payload_length <= wcfe_pkg::LEN16_MAX) begin
			form_in = wcfe_pkg::LEN_MED;
		end else begin
			form_in = wcfe_pkg::LEN_LONG;
		end
	end

	// header byte for the current index
	always_comb begin
		case (form_q)
			wcfe_pkg::LEN_SHORT: begin
				hdr_last_idx = wcfe_pkg::HDR_LAST_SHORT;
				key_pos      = wcfe_pkg::KEY_POS_SHORT;
				len_sel      = wcfe_pkg::LEN16_TOP_POS - hdr_idx_q;
			end
			wcfe_pkg::LEN_MED: begin
				hdr_last_idx = wcfe_pkg::HDR_LAST_MED;
				key_pos      = wcfe_pkg::KEY_POS_MED;
				len_sel      = wcfe_pkg::LEN16_TOP_POS - hdr_idx_q;
			end
			default: begin
				hdr_last_idx = wcfe_pkg::HDR_LAST_LONG;
				key_pos      = wcfe_pkg::KEY_POS_LONG;
				len_sel      = wcfe_pkg::LEN64_TOP_POS - hdr_idx_q;
			end
		endcase
		key_off     = hdr_idx_q - key_pos;
		in_key      = (hdr_idx_q >= key_pos);
		len_shifted = {1'b0, len_q} >> {len_sel[2:0], 3'b000};
		if (hdr_idx_q == 4'd0) begin
			hdr_byte = wcfe_pkg::FIN_BIT | {4'h0, type_q};
		end else if (hdr_idx_q == 4'd1) begin
			case (form_q)
				wcfe_pkg::LEN_SHORT: hdr_byte = wcfe_pkg::MASK_BIT | {1'b0, len_q[6:0]};
				wcfe_pkg::LEN_MED:   hdr_byte = wcfe_pkg::MASK_BIT | {1'b0, wcfe_pkg::ESC_LEN16};
				default:             hdr_byte = wcfe_pkg::MASK_BIT | {1'b0, wcfe_pkg::ESC_LEN64};
			endcase
		end else if (in_key) begin
			hdr_byte = key_byte(key_q, key_off[1:0]);
		end else begin
			hdr_byte = len_shifted[7:0];
		end
	end

	assign last_payload    = (bytes_left_q == wcfe_pkg::LEN_W'(1));
	assign status.out_free = !out_valid_q || out_ready;
	assign status.hdr_last = (hdr_idx_q == hdr_last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			key_q        <= '0;
			key_index_q  <= '0;
			frame_open_q <= 1'b0;
			hdr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.begin_load) begin
				bytes_left_q <= payload_length;
				key_q        <= masking_key;
				key_index_q  <= '0;
				frame_open_q <= (payload_length != '0);
				hdr_idx_q    <= '0;
			end else if (cmd.pay_load && frame_open_q) begin
				bytes_left_q <= bytes_left_q - wcfe_pkg::LEN_W'(1);
				key_index_q  <= key_index_q + 2'd1;
				if (last_payload) begin
					frame_open_q <= 1'b0;
				end
			end else if (cmd.hdr_emit) begin
				hdr_idx_q <= hdr_idx_q + 4'd1;
			end
			if (cmd.pay_load || cmd.hdr_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frame parameter and output registers
	always_ff @(posedge clk) begin
		if (cmd.begin_load) begin
			len_q      <= payload_length;
			type_q     <= frame_type;
			form_q     <= form_in;
			len_zero_q <= (payload_length == '0);
		end
		if (cmd.pay_load) begin
			if (frame_open_q) begin
				out_byte_q <= payload_byte ^ key_byte(key_q, key_index_q);
				last_q     <= 1'b1;
				done_q     <= last_payload;
				err_q      <= 1'b0;
			end else begin
				out_byte_q <= 8'h00;
				last_q     <= 1'b1;
				done_q     <= 1'b0;
				err_q      <= 1'b1;
			end
		end else if (cmd.hdr_emit) begin
			out_byte_q <= hdr_byte;
			last_q     <= status.hdr_last;
			done_q     <= status.hdr_last && len_zero_q;
			err_q      <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = last_q;
	assign frame_done   = done_q;
	assign error        = err_q;

endmodule
